// ----- hdl/acs_pkg.sv -----
package acs_pkg;

    // Shared multiplier: signed operands wide enough for a 24-bit sample or
    // for a zero-extended 24-bit half of a 48-bit word.
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 48;
    localparam int HALF_W  = ACC_W / 2;
    localparam int WIDE_W  = 2 * ACC_W;

    // Partial product sequencing for the 48 x 48 squares.
    localparam int PP_CNT_W = 3;
    localparam logic [PP_CNT_W-1:0] PP_LAST = 3'd4;

    // Divide and square root unit.
    localparam int SUB_W    = WIDE_W + 1;
    localparam int QUOT_W   = 32;
    localparam int ROOT_W   = QUOT_W / 2;
    localparam int SQ_REM_W = ROOT_W + 4;
    localparam int ITER_W   = 5;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int SQRT_STEPS = ROOT_W;

    // Result format.
    localparam int SIM_W       = 17;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;
    localparam logic [SIM_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AB,
        ST_AA,
        ST_BB,
        ST_ACC,
        ST_DSQ,
        ST_PSQ,
        ST_CMP,
        ST_WAIT,
        ST_FIN
    } acs_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } acs_ds_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } acs_ds_status_t;

endpackage

// ----- hdl/acs_mul.sv -----
module acs_mul
    import acs_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Registered product; the sequencer reads it in the cycle after issue.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/acs_divsqrt.sv -----
module acs_divsqrt
    import acs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [WIDE_W-1:0]   num_in,
    input  logic [WIDE_W-1:0]   den_in,
    output acs_ds_status_t      status,
    output logic [ROOT_W-1:0]   root
);

    acs_ds_phase_t       phase_reg, phase_next;
    logic [ITER_W-1:0]   iter_reg;
    logic [WIDE_W-1:0]   rem_reg;
    logic [WIDE_W-1:0]   den_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [SUB_W-1:0]    opx, opy;
    logic [SUB_W:0]      diff;
    logic                ge;
    logic [SQ_REM_W-1:0] rem4, trial;
    logic                div_end, sqrt_end;

    // The quotient 2^32 * num / den is formed first (num < den, so it fits in
    // 32 bits), then its integer square root, two radicand bits per step.
    // Both phases share one subtractor.
    assign rem4  = {rem_reg[SQ_REM_W-3:0], quot_reg[QUOT_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_comb begin
        opx = '0;
        opy = '0;
        case (phase_reg)
            DS_DIV: begin
                opx = {rem_reg, 1'b0};
                opy = {1'b0, den_reg};
            end
            DS_SQRT: begin
                opx = SUB_W'(rem4);
                opy = SUB_W'(trial);
            end
            default: begin
                opx = '0;
                opy = '0;
            end
        endcase
    end

    assign diff     = {1'b0, opx} - {1'b0, opy};
    assign ge       = ~diff[SUB_W];
    assign div_end  = (iter_reg == ITER_W'(DIV_STEPS - 1));
    assign sqrt_end = (iter_reg == ITER_W'(SQRT_STEPS - 1));

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            DS_IDLE: begin
                if (start) phase_next = DS_DIV;
            end
            DS_DIV: begin
                if (div_end) phase_next = DS_SQRT;
            end
            DS_SQRT: begin
                if (sqrt_end) phase_next = DS_DONE;
            end
            DS_DONE: phase_next = DS_IDLE;
            default: phase_next = DS_IDLE;
        endcase
    end

    always_comb begin
        status.busy = 1'b0;
        status.done = 1'b0;
        case (phase_reg)
            DS_IDLE: status.busy = 1'b0;
            DS_DIV, DS_SQRT: status.busy = 1'b1;
            DS_DONE: begin
                status.busy = 1'b1;
                status.done = 1'b1;
            end
            default: status.busy = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DS_IDLE;
            iter_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            if ((phase_reg == DS_DIV && div_end) || phase_reg == DS_IDLE) begin
                iter_reg <= '0;
            end else begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            DS_IDLE: begin
                if (start) begin
                    rem_reg  <= num_in;
                    den_reg  <= den_in;
                    quot_reg <= '0;
                end
            end
            DS_DIV: begin
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                if (div_end) begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                end else if (ge) begin
                    rem_reg <= diff[WIDE_W-1:0];
                end else begin
                    rem_reg <= opx[WIDE_W-1:0];
                end
            end
            DS_SQRT: begin
                quot_reg <= {quot_reg[QUOT_W-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                if (ge) begin
                    rem_reg <= WIDE_W'(diff[SQ_REM_W-1:0]);
                end else begin
                    rem_reg <= WIDE_W'(rem4);
                end
            end
            default: begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign root = root_reg;

endmodule

// ----- hdl/abs_cosine_similarity_unit.sv -----
// Channel   Direction  Beat contents (lowest bit first)                 Handshake
// s_*       in         tdata: elem_a, elem_b; tlast: last pair          s_tvalid/s_tready
// m_*       out        tdata: similarity; tuser: degenerate, overflow   m_tvalid/m_tready
//
// An element pair that is not the last passes through ST_AB, ST_AA, ST_BB and
// ST_ACC before the next acceptance: three products go through the one shared
// multiplier. A last pair goes on through the two 48 x 48 squares cut into
// 24-bit partial products, a compare, the shift and subtract divide (32 steps)
// and square root (16 steps), and the hand-off of the result; a zero norm or a
// saturated ratio skips the divide.
// Reset is synchronous and clears the accumulators; no clearing pass follows.
// A result waits in the output register until taken; the next pair is accepted
// meanwhile, and only the following result waits for the register to free.
module abs_cosine_similarity_unit
    import acs_pkg::*;
#(
    parameter int MAX_LEN      = 1024,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // s_tdata: elem_a [SAMPLE_WIDTH-1:0], elem_b above it, zero padding to bytes
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
    input  logic                                     s_tlast,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // m_tdata: similarity [16:0], zero padding [23:17]
    output logic [OUT_TDATA_W-1:0]                   m_tdata,
    // m_tuser: degenerate [0], overflow [1]
    output logic [OUT_TUSER_W-1:0]                   m_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready
);

    // The count saturates at MAX_LEN + 1, which marks an over-long vector.
    localparam int CNT_W = $clog2(MAX_LEN + 2);

    acs_state_t state_reg, state_next;

    logic signed [SAMPLE_WIDTH-1:0] a_reg, b_reg;
    logic                           last_reg;

    logic [ACC_W-1:0]  dot_acc_reg, sumsq_a_acc_reg, sumsq_b_acc_reg;
    logic [CNT_W-1:0]  elem_count_reg;
    logic              acc_en;

    logic [PP_CNT_W-1:0] pp_cnt_reg;
    logic [WIDE_W-1:0]   d_reg, p_reg;
    logic [WIDE_W-1:0]   pp_term;

    logic [SIM_W-1:0] sim_reg;
    logic             degen_reg, ovf_reg;
    logic [SIM_W-1:0] m_sim_reg;
    logic             m_degen_reg, m_ovf_reg, m_tvalid_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         sq_x, sq_y;
    logic                     degen, sat, out_free;

    acs_ds_status_t    ds_status;
    logic              ds_start;
    logic [ROOT_W-1:0] ds_root;

    // Pairs past MAX_LEN still flow through the sequence but add nothing.
    assign acc_en   = (elem_count_reg < CNT_W'(MAX_LEN));
    assign mag      = dot_acc_reg[ACC_W-1] ? (~dot_acc_reg + ACC_W'(1)) : dot_acc_reg;
    assign degen    = (sumsq_a_acc_reg == '0) || (sumsq_b_acc_reg == '0);
    assign sat      = (d_reg >= p_reg);
    assign out_free = ~m_tvalid_reg | m_tready;

    // The squares work on dot^2 first, then sum_a * sum_b.
    assign sq_x = (state_reg == ST_DSQ) ? mag : sumsq_a_acc_reg;
    assign sq_y = (state_reg == ST_DSQ) ? mag : sumsq_b_acc_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_AB;
            end
            ST_AB:  state_next = ST_AA;
            ST_AA:  state_next = ST_BB;
            ST_BB:  state_next = ST_ACC;
            ST_ACC: state_next = last_reg ? ST_DSQ : ST_IDLE;
            ST_DSQ: begin
                if (pp_cnt_reg == PP_LAST) state_next = ST_PSQ;
            end
            ST_PSQ: begin
                if (pp_cnt_reg == PP_LAST) state_next = ST_CMP;
            end
            ST_CMP: state_next = (degen || sat) ? ST_FIN : ST_WAIT;
            ST_WAIT: begin
                if (ds_status.done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider start.
    always_comb begin
        s_tready = 1'b0;
        ds_start = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_AB: begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(b_reg);
            end
            ST_AA: begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(a_reg);
            end
            ST_BB: begin
                mul_a = MUL_W'(b_reg);
                mul_b = MUL_W'(b_reg);
            end
            ST_DSQ, ST_PSQ: begin
                // Partial products low*low, low*high, high*low, high*high.
                mul_a = pp_cnt_reg[1] ? {1'b0, sq_x[ACC_W-1:HALF_W]}
                                      : {1'b0, sq_x[HALF_W-1:0]};
                mul_b = pp_cnt_reg[0] ? {1'b0, sq_y[ACC_W-1:HALF_W]}
                                      : {1'b0, sq_y[HALF_W-1:0]};
            end
            ST_CMP: ds_start = ~(degen | sat);
            default: s_tready = 1'b0;
        endcase
    end

    // Weight of the partial product that the multiplier returns this cycle.
    always_comb begin
        case (pp_cnt_reg)
            3'd1:       pp_term = WIDE_W'(prod[ACC_W-1:0]);
            3'd2, 3'd3: pp_term = WIDE_W'(prod[ACC_W-1:0]) << HALF_W;
            3'd4:       pp_term = WIDE_W'(prod[ACC_W-1:0]) << ACC_W;
            default:    pp_term = '0;
        endcase
    end

    acs_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    acs_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .num_in  (d_reg),
        .den_in  (p_reg),
        .status  (ds_status),
        .root    (ds_root)
    );

    // Control state and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pp_cnt_reg      <= '0;
            dot_acc_reg     <= '0;
            sumsq_a_acc_reg <= '0;
            sumsq_b_acc_reg <= '0;
            elem_count_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if ((state_reg == ST_DSQ || state_reg == ST_PSQ) && pp_cnt_reg != PP_LAST) begin
                pp_cnt_reg <= pp_cnt_reg + PP_CNT_W'(1);
            end else begin
                pp_cnt_reg <= '0;
            end

            if (acc_en) begin
                if (state_reg == ST_AA) dot_acc_reg     <= dot_acc_reg + prod[ACC_W-1:0];
                if (state_reg == ST_BB) sumsq_a_acc_reg <= sumsq_a_acc_reg + prod[ACC_W-1:0];
                if (state_reg == ST_ACC) begin
                    sumsq_b_acc_reg <= sumsq_b_acc_reg + prod[ACC_W-1:0];
                    elem_count_reg  <= elem_count_reg + CNT_W'(1);
                end
            end else if (state_reg == ST_ACC) begin
                elem_count_reg <= CNT_W'(MAX_LEN + 1);
            end

            if (state_reg == ST_FIN && out_free) begin
                // Result handed off: start the next vector pair from zero.
                dot_acc_reg     <= '0;
                sumsq_a_acc_reg <= '0;
                sumsq_b_acc_reg <= '0;
                elem_count_reg  <= '0;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            a_reg    <= s_tdata[SAMPLE_WIDTH-1:0];
            b_reg    <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
            last_reg <= s_tlast;
        end

        if (state_reg == ST_DSQ && pp_cnt_reg != '0) begin
            d_reg <= (pp_cnt_reg == PP_CNT_W'(1)) ? pp_term : d_reg + pp_term;
        end
        if (state_reg == ST_PSQ && pp_cnt_reg != '0) begin
            p_reg <= (pp_cnt_reg == PP_CNT_W'(1)) ? pp_term : p_reg + pp_term;
        end

        if (state_reg == ST_CMP) begin
            degen_reg <= degen;
            ovf_reg   <= (elem_count_reg > CNT_W'(MAX_LEN));
            // A ratio of one or more (above one only after a wrap) saturates at 1.0.
            sim_reg   <= degen ? '0 : ONE_Q16;
        end else if (state_reg == ST_WAIT && ds_status.done) begin
            sim_reg <= SIM_W'(ds_root);
        end

        if (state_reg == ST_FIN && out_free) begin
            m_sim_reg   <= sim_reg;
            m_degen_reg <= degen_reg;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - SIM_W){1'b0}}, m_sim_reg};
    assign m_tuser  = {m_ovf_reg, m_degen_reg};

`ifndef ASSERT_OFF
    // The divide unit only runs while the sequencer waits for it.
    a_ds_busy_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_status.busy |-> (state_reg == ST_WAIT))
        else $error("divide unit busy outside the wait state");

    // A degenerate result always carries a zero similarity.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[SIM_W-1:0] == '0))
        else $error("degenerate result with nonzero similarity");

    // The similarity never exceeds 1.0.
    a_sim_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SIM_W-1:0] <= ONE_Q16))
        else $error("similarity above 1.0");

    // The pair count saturates just past MAX_LEN.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        elem_count_reg <= CNT_W'(MAX_LEN + 1))
        else $error("pair count beyond saturation");

    // A beat is taken only when the previous pair has finished its products.
    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_AB))
        else $error("accepted beat did not start the product sequence");
`endif

endmodule

// ----- verif/abs_cosine_similarity_unit_tb.sv -----
// Self-checking bench for the absolute cosine similarity unit.
//
// Element pairs go in on the s_ channel, one pair per beat; the beat with
// s_tlast high closes the vector pair and makes the block produce one result
// beat on the m_ channel. The bench keeps its own bit-exact model of the
// accumulators. Each accepted input beat is folded into that model, and a
// closing beat appends the expected result to a queue. The output monitor pops
// the queue on every accepted result beat and compares each field.
//
// Stimulus comes in two parts. A directed table covers the corners: zero norms
// on either side, full-scale elements, parallel and antiparallel vectors, a
// vector of exactly the maximum length, and one that is a pair too long.
// Rows whose answer is plain from the math carry it typed in; the rest are
// checked against the model. Random vectors follow, mostly short, with some
// longer ones. Somewhere in the middle the result side holds off for a long
// stretch while short vectors keep coming, so the output register fills and
// the input side has to stall. Both sides idle in short random bursts, except
// in the closing part of the run.
module abs_cosine_similarity_unit_tb
    import acs_pkg::*;
();

    localparam int PAIR_LIMIT  = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int DATA_W      = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 900;
    localparam int QUIET_ITEMS = 120;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 80;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 24;

    // One result beat as the bench sees it.
    typedef struct packed {
        logic [SIM_W-1:0] sim;
        logic             degen;
        logic             ovf;
    } sim_result_t;

    // One directed row sends reps pairs of (a, b). Only the final pair of the
    // row carries the row's last flag. When known is set, the row's answer is
    // typed in and replaces the model's.
    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
        int                 reps;
        bit                 known;
        sim_result_t        want;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic [DATA_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;

    // Model state, mirroring the block's accumulators.
    logic [47:0] dot_sum;
    logic [47:0] norm_a_sum;
    logic [47:0] norm_b_sum;
    int unsigned pair_cnt;

    sim_result_t similarity_q[$];
    int          fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Shared between the sender and the result sink, but for allow_gaps, which only the sender uses.
    bit quiet = 1'b0;
    bit allow_gaps = 1'b0;
    bit hold_request = 1'b0;

    localparam sim_result_t NONE   = '{sim: '0, degen: 1'b0, ovf: 1'b0};
    localparam sim_result_t DEGEN  = '{sim: '0, degen: 1'b1, ovf: 1'b0};
    localparam sim_result_t UNITY  = '{sim: 17'h10000, degen: 1'b0, ovf: 1'b0};
    localparam sim_result_t UNITYO = '{sim: 17'h10000, degen: 1'b0, ovf: 1'b1};

    dir_row_t dir_table [DIR_ROWS] = '{
        // Right after reset both vectors are zero: degenerate.
        '{16'sd0,     16'sd0,     1'b1, 1,    1'b1, DEGEN},
        // Only the second vector has zero norm.
        '{16'sd4096,  16'sd0,     1'b1, 1,    1'b1, DEGEN},
        // Only the first vector has zero norm, second at full negative scale.
        '{16'sd0,     16'sh8000,  1'b1, 1,    1'b1, DEGEN},
        // Single-element vectors are always parallel or antiparallel.
        '{16'sh8000,  16'sh8000,  1'b1, 1,    1'b1, UNITY},
        '{16'sd32767, 16'sh8000,  1'b1, 1,    1'b1, UNITY},
        '{16'sd1,     -16'sd1,    1'b1, 1,    1'b1, UNITY},
        // Orthogonal pair gives a zero dot product but nonzero norms.
        '{16'sd1,     16'sd0,     1'b0, 1,    1'b0, NONE},
        '{16'sd0,     16'sd1,     1'b1, 1,    1'b1, NONE},
        // Mixed full-scale elements, left to the model.
        '{16'sd32767, 16'sd12345, 1'b0, 1,    1'b0, NONE},
        '{16'sh8000,  16'sd32767, 1'b0, 1,    1'b0, NONE},
        '{-16'sd7,    16'sd100,   1'b1, 1,    1'b0, NONE},
        // Forty-five degrees apart.
        '{16'sd1,     16'sd1,     1'b0, 1,    1'b0, NONE},
        '{16'sd1,     16'sd0,     1'b1, 1,    1'b0, NONE},
        // A zero pair adds nothing, so the one real pair decides the result.
        '{16'sd0,     16'sd0,     1'b0, 1,    1'b0, NONE},
        '{16'sd5,     16'sd3,     1'b1, 1,    1'b1, UNITY},
        // Exactly the maximum length: no overflow.
        '{-16'sd1,    16'sd2,     1'b0, 1023, 1'b0, NONE},
        '{-16'sd1,    16'sd2,     1'b1, 1,    1'b1, UNITY},
        // One pair too many: the extra antiparallel-breaking pair is dropped.
        '{16'sd3,     16'sd3,     1'b0, 1024, 1'b0, NONE},
        '{16'sd3,     -16'sd3,    1'b1, 1,    1'b1, UNITYO},
        // The count must start over after an overlong vector.
        '{16'sh8000,  16'sd32767, 1'b0, 1,    1'b0, NONE},
        '{16'sd32767, 16'sh8000,  1'b1, 1,    1'b0, NONE},
        '{16'sd32767, 16'sd32767, 1'b0, 3,    1'b0, NONE},
        '{16'sh8000,  16'sd1234,  1'b1, 1,    1'b0, NONE},
        // An alternating bit pattern against its negation.
        '{16'shAAAA,  16'sh5556,  1'b1, 1,    1'b1, UNITY}
    };

    abs_cosine_similarity_unit #(
        .MAX_LEN      (PAIR_LIMIT),
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 aclk = ~aclk;

    // Largest Q1.16 value r, capped at 1.0, with r^2 * sum_a * sum_b no greater
    // than dot^2 * 2^32. The bit-by-bit search keeps the answer an exact floor.
    function automatic logic [SIM_W-1:0] q16_ratio(input logic [47:0] dot,
                                                   input logic [47:0] sum_a,
                                                   input logic [47:0] sum_b);
        logic [47:0]      mag;
        logic [191:0]     dot_sq;
        logic [191:0]     norm_prod;
        logic [191:0]     cand_sq;
        logic [191:0]     scratch;
        logic [SIM_W-1:0] root;
        logic [SIM_W-1:0] cand;
        int               k;
        mag = dot[47] ? -dot : dot;
        dot_sq = mag;
        dot_sq = (dot_sq * dot_sq) << 32;
        norm_prod = sum_a;
        scratch = sum_b;
        norm_prod = norm_prod * scratch;
        root = '0;
        for (k = SIM_W - 1; k >= 0; k--) begin
            cand = root;
            cand[k] = 1'b1;
            if (cand <= ONE_Q16) begin
                cand_sq = cand;
                scratch = cand_sq * cand_sq * norm_prod;
                if (scratch <= dot_sq)
                    root = cand;
            end
        end
        return root;
    endfunction

    // Folds one accepted pair into the model. Returns 1, with the result, when
    // the pair closes the vectors; the model then starts over from zero.
    // The sample width equals the field width here, so no masking is needed.
    function automatic bit fold_pair(input logic [15:0] a_raw, input logic [15:0] b_raw,
                                     input logic last, output sim_result_t res);
        logic signed [47:0] a;
        logic signed [47:0] b;
        a = $signed(a_raw);
        b = $signed(b_raw);
        res = NONE;
        if (pair_cnt < PAIR_LIMIT) begin
            dot_sum    = dot_sum + a * b;
            norm_a_sum = norm_a_sum + a * a;
            norm_b_sum = norm_b_sum + b * b;
            pair_cnt++;
        end else begin
            pair_cnt = PAIR_LIMIT + 1;
        end
        if (!last)
            return 1'b0;
        res.ovf   = pair_cnt > PAIR_LIMIT;
        res.degen = (norm_a_sum == '0) || (norm_b_sum == '0);
        if (!res.degen)
            res.sim = q16_ratio(dot_sum, norm_a_sum, norm_b_sum);
        dot_sum    = '0;
        norm_a_sum = '0;
        norm_b_sum = '0;
        pair_cnt   = 0;
        return 1'b1;
    endfunction

    // Offers one pair and waits for the handshake. After acceptance the pair is
    // folded into the model, then the sender may idle for a short burst with
    // junk on the data lines while tvalid is low.
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                             input logic last, input bit known, input sim_result_t want);
        sim_result_t res;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (fold_pair(a, b, last, res)) begin
            res = known ? want : res;
            similarity_q = {similarity_q, res};
        end
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= DATA_W'($urandom);
            s_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 5))
                @(posedge aclk);
        end
    endtask

    // Sends one vector pair of the given length. The content style is picked
    // per vector so that exact unity, zero norms and small values all show up.
    task automatic send_random_vector(input int len, input bit gaps_ok);
        int                 style;
        int                 k;
        logic signed [15:0] a;
        logic signed [15:0] b;
        style = $urandom_range(0, 9);
        allow_gaps = gaps_ok && ($urandom_range(0, 2) != 0);
        for (k = 0; k < len; k++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (style)
                0: begin
                    b = a;
                end
                1: begin
                    b = -a;
                end
                2: begin
                    a = 16'($urandom_range(0, 15)) - 16'sd8;
                    b = 16'($urandom_range(0, 15)) - 16'sd8;
                end
                3: begin
                    a = '0;
                end
                4: begin
                    b = a >>> $urandom_range(0, 6);
                end
                default: begin
                end
            endcase
            send_pair(a, b, k == len - 1, 1'b0, NONE);
        end
    endtask

    // Cycle budget. A correct run stays far below it.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result sink. It mostly takes beats, stalls in short bursts, and once
    // holds off for a long stretch when the sender asks for pressure.
    initial begin : result_sink
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5))
                    @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16))
                    @(posedge aclk);
            end
        end
    end

    // Output monitor. Every accepted result beat must match the oldest
    // expectation field by field.
    always @(posedge aclk) begin : result_check
        sim_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (similarity_q.size() == 0) begin
                $error("result beat with nothing expected: similarity %0d",
                       m_tdata[SIM_W-1:0]);
                fail_cnt++;
            end else begin
                want = similarity_q.pop_front();
                if (m_tdata[SIM_W-1:0] !== want.sim) begin
                    $error("similarity: expected %0d, got %0d", want.sim,
                           m_tdata[SIM_W-1:0]);
                    fail_cnt++;
                end
                if (m_tuser[0] !== want.degen) begin
                    $error("degenerate: expected %0b, got %0b", want.degen, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tuser[1] !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, m_tuser[1]);
                    fail_cnt++;
                end
            end
        end
    end

    // Reset, directed table, random vectors, then drain and report.
    initial begin : stimulus
        int  row;
        int  rep;
        int  rand_items;
        int  len;
        int  k;
        bit  pressure_done;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        dot_sum    = '0;
        norm_a_sum = '0;
        norm_b_sum = '0;
        pair_cnt   = 0;
        rand_items    = 0;
        pressure_done = 1'b0;
        repeat (2)
            @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Gaps stay on so the corners also see idle beats.
        allow_gaps = 1'b1;
        for (row = 0; row < DIR_ROWS; row++) begin
            for (rep = 0; rep < dir_table[row].reps; rep++) begin
                send_pair(dir_table[row].a, dir_table[row].b,
                          dir_table[row].last && (rep == dir_table[row].reps - 1),
                          dir_table[row].known, dir_table[row].want);
            end
        end

        // Random part, mostly short vectors with the occasional longer one.
        while (rand_items < RAND_ITEMS) begin
            quiet = rand_items >= RAND_ITEMS - QUIET_ITEMS;
            if (!pressure_done && rand_items >= 200) begin
                // Many single-pair vectors back to back against a stalled
                // sink: the output register fills and s_tready must drop.
                pressure_done = 1'b1;
                hold_request = 1'b1;
                for (k = 0; k < 16; k++)
                    send_random_vector(1, 1'b0);
                rand_items += 16;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_random_vector(len, !quiet);
                rand_items += len;
            end
        end
        s_tvalid <= 1'b0;

        // Drain every expected result, then allow one more result's latency
        // so that a stray beat would still be caught.
        while (similarity_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT)
            @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/acs_pkg.sv
hdl/acs_mul.sv
hdl/acs_divsqrt.sv
hdl/abs_cosine_similarity_unit.sv
verif/abs_cosine_similarity_unit_tb.sv
